// ===== src/sorted_timer_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define STQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_timer_queue: same-cycle check failed");
// Next-cycle implication.
`define STQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_timer_queue: next-cycle check failed");
// Invariant that holds at every edge.
`define STQ_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted_timer_queue: invariant failed");
`else
`define STQ_ASSERT_IMP(lbl, ante, cons)
`define STQ_ASSERT_NXT(lbl, ante, cons)
`define STQ_ASSERT_ALW(lbl, cond)
`endif

`endif

// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Sizes, operation and result codes, and the control and status bundles.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Queue sizing.
  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;

  localparam int FIELD_W = 48;
  localparam int ID_W    = 8;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int FCNT_W  = $clog2(MAX_RESULTS + 1);

  // Times are compared after masking to TIME_BITS.
  localparam logic [FIELD_W-1:0] TIME_MASK =
      (TIME_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                             : FIELD_W'((64'd1 << TIME_BITS) - 64'd1);

  // Requested operation.
  typedef enum logic [1:0] {
    ACT_SCHEDULE   = 2'd0,
    ACT_UNSCHEDULE = 2'd1,
    ACT_UPDATE     = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  // Result codes.
  typedef enum logic [2:0] {
    KIND_FIRED     = 3'd0,
    KIND_EARLY     = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic schedule;
    logic unschedule;
    logic fire;
  } stq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic head_due;
    logic next_due;
  } stq_status_t;

endpackage

// ===== src/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue controller
// Sequences one request at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          action_i,
  output logic                in_ready_o,
  input  stq_pkg::stq_status_t status_i,
  output stq_pkg::stq_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRE
  } state_e;

  state_e            state_q, state_d;
  stq_pkg::action_e  action_q;
  logic              in_ready_q;
  logic              accept;

  assign accept     = in_valid_i && in_ready_q;
  assign in_ready_o = in_ready_q;

  // Command decode and next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (action_q)
          stq_pkg::ACT_SCHEDULE: begin
            if (status_i.out_free) begin
              cmd_o.schedule = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          stq_pkg::ACT_UNSCHEDULE: begin
            if (status_i.out_free) begin
              cmd_o.unschedule = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          stq_pkg::ACT_UPDATE: begin
            state_d = status_i.head_due ? ST_FIRE : ST_IDLE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FIRE: begin
        // The head is known to be due here; fire it once the output is free.
        if (status_i.out_free) begin
          cmd_o.fire = 1'b1;
          if (!status_i.next_due) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, latched action and registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      action_q   <= stq_pkg::ACT_NONE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == ST_IDLE);
      if (accept) begin
        action_q <= stq_pkg::action_e'(action_i);
      end
    end
  end

endmodule

// ===== src/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue datapath
// Sorted shift-register queue, request registers and the result register.
// ----------------------------------------------------------------------------
module stq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [stq_pkg::ID_W-1:0]          entry_id_i,
  input  logic [stq_pkg::FIELD_W-1:0]       deadline_i,
  input  logic [stq_pkg::FIELD_W-1:0]       now_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [2:0]                        result_kind_o,
  output logic [stq_pkg::ID_W-1:0]          out_id_o,
  output logic [stq_pkg::FIELD_W-1:0]       fire_time_o,
  output logic                              last_o,
  input  stq_pkg::stq_cmd_t                 cmd_i,
  output stq_pkg::stq_status_t              status_o
);

  localparam int DEPTH = stq_pkg::DEPTH;
  localparam int TW    = stq_pkg::FIELD_W;
  localparam int IW    = stq_pkg::ID_W;
  localparam int CW    = stq_pkg::COUNT_W;
  localparam int FW    = stq_pkg::FCNT_W;

  // Queue storage, entry 0 is the head.
  logic [TW-1:0] dl_q [DEPTH];
  logic [IW-1:0] id_q [DEPTH];
  logic [TW-1:0] dl_d [DEPTH];
  logic [IW-1:0] id_d [DEPTH];
  logic [CW-1:0] count_q;
  logic [FW-1:0] fire_cnt_q;

  // Latched request.
  logic [IW-1:0] req_id_q;
  logic [TW-1:0] req_dl_q;
  logic [TW-1:0] req_now_q;

  // Result register.
  logic          out_valid_q;
  logic [2:0]    kind_q;
  logic [IW-1:0] out_id_q;
  logic [TW-1:0] fire_time_q;
  logic          last_q;

  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] found_upto;
  logic             full;
  logic             found;
  logic             out_free;

  assign full     = (count_q == CW'(DEPTH));
  assign found    = found_upto[DEPTH-1];
  assign out_free = !out_valid_q || out_ready_i;

  // Status for the controller.
  assign status_o.out_free = out_free;
  assign status_o.head_due = (count_q != '0) && (dl_q[0] <= req_now_q) &&
                             (fire_cnt_q < FW'(stq_pkg::MAX_RESULTS));
  assign status_o.next_due = (count_q > CW'(1)) && (dl_q[1] <= req_now_q) &&
                             (FW'(fire_cnt_q + FW'(1)) < FW'(stq_pkg::MAX_RESULTS));

  // Per-entry compares; valid entries earlier than the new deadline form a prefix.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i]    = (CW'(i) < count_q) && (dl_q[i] < req_dl_q);
      match[i] = (CW'(i) < count_q) && (id_q[i] == req_id_q);
    end
    found_upto[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      found_upto[i] = found_upto[i-1] | match[i];
    end
  end

  // Next queue contents for insert, remove and fire.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      dl_d[i] = dl_q[i];
      id_d[i] = id_q[i];
      if (cmd_i.schedule && !full) begin
        if (!lt[i]) begin
          if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
            dl_d[i] = req_dl_q;
            id_d[i] = req_id_q;
          end else begin
            dl_d[i] = dl_q[(i == 0) ? 0 : i-1];
            id_d[i] = id_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if ((cmd_i.unschedule && found_upto[i]) || cmd_i.fire) begin
        if (i < DEPTH-1) begin
          dl_d[i] = dl_q[(i < DEPTH-1) ? i+1 : i];
          id_d[i] = id_q[(i < DEPTH-1) ? i+1 : i];
        end
      end
    end
  end

  // Control registers: entry count, firing count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fire_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        fire_cnt_q <= '0;
      end else if (cmd_i.fire) begin
        fire_cnt_q <= FW'(fire_cnt_q + FW'(1));
      end
      if (cmd_i.schedule && !full) begin
        count_q <= CW'(count_q + CW'(1));
      end else if ((cmd_i.unschedule && found) || cmd_i.fire) begin
        count_q <= CW'(count_q - CW'(1));
      end
      if (cmd_i.schedule || cmd_i.unschedule || cmd_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: queue, request and result fields.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      dl_q[i] <= dl_d[i];
      id_q[i] <= id_d[i];
    end
    if (cmd_i.load) begin
      req_id_q  <= entry_id_i;
      req_dl_q  <= deadline_i & stq_pkg::TIME_MASK;
      req_now_q <= now_i & stq_pkg::TIME_MASK;
    end
    if (cmd_i.schedule) begin
      kind_q      <= full ? stq_pkg::KIND_FULL : stq_pkg::KIND_EARLY;
      out_id_q    <= req_id_q;
      fire_time_q <= '0;
      last_q      <= 1'b1;
    end else if (cmd_i.unschedule) begin
      kind_q      <= found ? stq_pkg::KIND_REMOVED : stq_pkg::KIND_NOT_FOUND;
      out_id_q    <= req_id_q;
      fire_time_q <= '0;
      last_q      <= 1'b1;
    end else if (cmd_i.fire) begin
      kind_q      <= stq_pkg::KIND_FIRED;
      out_id_q    <= id_q[0];
      fire_time_q <= req_now_q;
      last_q      <= !status_o.next_due;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign out_id_o      = out_id_q;
  assign fire_time_o   = fire_time_q;
  assign last_o        = last_q;

endmodule

// ===== src/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted timer queue
// Deadline-ordered timer queue with schedule, unschedule and time update.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries sorted by deadline in a shift-register
// line, so insert and remove each take one shift. A schedule or unschedule
// request loads the request registers on its transfer in and writes its
// result register from the execute state once that register is free; the
// next request can transfer only after the controller is back in idle. An
// update checks the head in the cycle after its transfer and then fires one
// entry per cycle while the result side takes them, at most sixteen, paced
// by the single result register. An update with nothing due produces no
// result. The queue needs no clearing pass after reset.
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [stq_pkg::ID_W-1:0]    entry_id_i,
  input  logic [stq_pkg::FIELD_W-1:0] deadline_i,
  input  logic [stq_pkg::FIELD_W-1:0] now_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  result_kind_o,
  output logic [stq_pkg::ID_W-1:0]    out_id_o,
  output logic [stq_pkg::FIELD_W-1:0] fire_time_o,
  output logic                        last_o
);

  stq_pkg::stq_cmd_t    cmd;
  stq_pkg::stq_status_t status;

  // Request sequencing.
  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Queue storage and result register.
  stq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_id_i    (entry_id_i),
    .deadline_i    (deadline_i),
    .now_i         (now_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .out_id_o      (out_id_o),
    .fire_time_o   (fire_time_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  // A transfer in always leaves the idle state, so ready is low in the next cycle.
  `STQ_ASSERT_NXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)
  // Only one command is issued at a time.
  `STQ_ASSERT_ALW(a_cmd_onehot, $onehot0({cmd.load, cmd.schedule, cmd.unschedule, cmd.fire}))
  // A result is written only when the result register can take it.
  `STQ_ASSERT_IMP(a_result_room, cmd.schedule || cmd.unschedule || cmd.fire, status.out_free)
  // Only a due head entry fires.
  `STQ_ASSERT_IMP(a_fire_due, cmd.fire, status.head_due)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted timer queue testbench
// Drives schedule, unschedule and time update requests into the queue and
// checks every result against a predictor of the deadline-ordered queue or a hand-written result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 54;
  localparam int PRESSURE_ITEMS = 30;
  localparam int FILL_ITEMS     = 13;
  localparam int FW             = stq_pkg::FIELD_W;
  localparam int IW             = stq_pkg::ID_W;
  localparam logic [FW-1:0] T_MAX = stq_pkg::TIME_MASK;

  // One result transfer as the queue reports it.
  typedef struct {
    stq_pkg::kind_e      kind;
    logic [IW-1:0]       id;
    logic [FW-1:0]       fire_time;
    logic                last;
  } timer_result_t;

  // One request transfer, with an optional hand-written result.
  typedef struct {
    stq_pkg::action_e    act;
    logic [IW-1:0]       id;
    logic [FW-1:0]       dl;
    logic [FW-1:0]       tnow;
    bit                  typed;
    timer_result_t       want;
  } request_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i       = '0;
  logic [IW-1:0]       entry_id_i     = '0;
  logic [FW-1:0]       deadline_i     = '0;
  logic [FW-1:0]       now_i          = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [2:0]          result_kind_o;
  logic [IW-1:0]       out_id_o;
  logic [FW-1:0]       fire_time_o;
  logic                last_o;

  // Predicted queue contents, head at entry 0.
  logic [FW-1:0]       sched_dl [stq_pkg::DEPTH];
  logic [IW-1:0]       sched_id [stq_pkg::DEPTH];
  int                  sched_count = 0;

  timer_result_t       pending_results [$];
  int                  errors         = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_req       = 1'b0;
  bit                  hold_done      = 1'b0;
  int                  hold_left      = 0;
  int unsigned         cycle_count    = 0;
  logic [FW-1:0]       time_base      = '0;

  sorted_timer_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_id_i    (entry_id_i),
    .deadline_i    (deadline_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_id_o      (out_id_o),
    .fire_time_o   (fire_time_o),
    .last_o        (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic timer_result_t make_result(stq_pkg::kind_e k, logic [IW-1:0] id,
                                                logic [FW-1:0] t, logic last);
    timer_result_t r;
    r.kind      = k;
    r.id        = id;
    r.fire_time = t;
    r.last      = last;
    return r;
  endfunction

  function automatic request_t req_row(stq_pkg::action_e a, logic [IW-1:0] id,
                                       logic [FW-1:0] dl, logic [FW-1:0] tn);
    request_t req;
    req.act   = a;
    req.id    = id;
    req.dl    = dl;
    req.tnow  = tn;
    req.typed = 1'b0;
    req.want  = make_result(stq_pkg::KIND_FIRED, '0, '0, 1'b0);
    return req;
  endfunction

  // Attaches a single, hand-written result to a request.
  function automatic request_t with_result(request_t req, stq_pkg::kind_e k,
                                           logic [IW-1:0] id, logic [FW-1:0] t);
    req.typed = 1'b1;
    req.want  = make_result(k, id, t, 1'b1);
    return req;
  endfunction

  function automatic logic [FW-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[FW-1:0];
  endfunction

  // Applies one request to the predicted queue and, when asked, records the
  // results that it causes.
  task automatic apply_timer_request(input request_t req, input bit record);
    logic [FW-1:0]      dl;
    logic [FW-1:0]      tnow;
    int                 pos;
    int                 fired;
    int                 i;
    timer_result_t      outs [$];
    dl   = req.dl & stq_pkg::TIME_MASK;
    tnow = req.tnow & stq_pkg::TIME_MASK;
    case (req.act)
      stq_pkg::ACT_SCHEDULE: begin
        if (sched_count >= stq_pkg::DEPTH) begin
          outs.push_back(make_result(stq_pkg::KIND_FULL, req.id, '0, 1'b1));
        end else begin
          // Insert ahead of every entry with an equal or later deadline.
          pos = 0;
          while (pos < sched_count && sched_dl[pos] < dl) pos++;
          for (i = sched_count; i > pos; i--) begin
            sched_dl[i] = sched_dl[i-1];
            sched_id[i] = sched_id[i-1];
          end
          sched_dl[pos] = dl;
          sched_id[pos] = req.id;
          sched_count++;
          outs.push_back(make_result(stq_pkg::KIND_EARLY, req.id, '0, 1'b1));
        end
      end
      stq_pkg::ACT_UNSCHEDULE: begin
        pos = 0;
        while (pos < sched_count && sched_id[pos] != req.id) pos++;
        if (pos >= sched_count) begin
          outs.push_back(make_result(stq_pkg::KIND_NOT_FOUND, req.id, '0, 1'b1));
        end else begin
          for (i = pos; i + 1 < sched_count; i++) begin
            sched_dl[i] = sched_dl[i+1];
            sched_id[i] = sched_id[i+1];
          end
          sched_count--;
          outs.push_back(make_result(stq_pkg::KIND_REMOVED, req.id, '0, 1'b1));
        end
      end
      stq_pkg::ACT_UPDATE: begin
        // Fire due entries from the head; nothing is reported if none is due.
        fired = 0;
        while (fired < sched_count && fired < stq_pkg::MAX_RESULTS &&
               sched_dl[fired] <= tnow) begin
          outs.push_back(make_result(stq_pkg::KIND_FIRED, sched_id[fired], tnow, 1'b0));
          fired++;
        end
        if (fired > 0) begin
          outs[fired-1].last = 1'b1;
          for (i = 0; i + fired < sched_count; i++) begin
            sched_dl[i] = sched_dl[i+fired];
            sched_id[i] = sched_id[i+fired];
          end
          sched_count -= fired;
        end
      end
      default: ;
    endcase
    if (record) begin
      foreach (outs[k]) pending_results.push_back(outs[k]);
    end
  endtask

  // Mostly well-formed traffic: ids and times drawn from the queue contents,
  // with fully random fields mixed in.
  function automatic request_t random_request(input int sched_pct);
    request_t      req;
    int            sel;
    int            pick;
    logic [IW-1:0] rid;
    rid  = ($urandom_range(1) == 0) ? IW'($urandom_range(7)) : IW'($urandom);
    req  = req_row(stq_pkg::ACT_NONE, rid, rand_time(), rand_time());
    sel  = $urandom_range(99);
    pick = (sched_count > 0) ? $urandom_range(sched_count - 1) : 0;
    if (sel < sched_pct) begin
      req.act = stq_pkg::ACT_SCHEDULE;
      case ($urandom_range(9))
        0, 1, 2, 3: req.dl = time_base + FW'($urandom_range(500));
        4, 5:       if (sched_count > 0) req.dl = sched_dl[pick];
        6:          req.dl = '0;
        7:          req.dl = T_MAX;
        default:    ;
      endcase
    end else if (sel < sched_pct + 20) begin
      req.act = stq_pkg::ACT_UNSCHEDULE;
      if (sched_count > 0 && $urandom_range(4) != 0) req.id = sched_id[pick];
    end else if (sel < 96) begin
      req.act = stq_pkg::ACT_UPDATE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: if (sched_count > 0) req.tnow = sched_dl[pick];
        5:             if (sched_count > 0) req.tnow = sched_dl[pick] - FW'(1);
        6, 7:          req.tnow = time_base + FW'($urandom_range(600));
        8:             req.tnow = ($urandom_range(1) == 0) ? '0 : T_MAX;
        default:       ;
      endcase
    end
    return req;
  endfunction

  // Offers one request and waits for its transfer.
  task automatic send_request(input request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= req.act;
    entry_id_i <= req.id;
    deadline_i <= req.dl;
    now_i      <= req.tnow;
    do @(posedge clk_i); while (!in_ready_o);
    apply_timer_request(req, !req.typed);
    if (req.typed) pending_results.push_back(req.want);
  endtask

  task automatic check_field(input string name, input logic [FW-1:0] want,
                             input logic [FW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: check each transfer and drive the ready with random stalls
  // and one long hold-off.
  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, kind %0d id %0h time %0h last %0b",
                   $time, result_kind_o, out_id_o, fire_time_o, last_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", FW'(want.kind), FW'(result_kind_o));
          check_field("out_id", FW'(want.id), FW'(out_id_o));
          check_field("fire_time", want.fire_time, fire_time_o);
          check_field("last", FW'(want.last), FW'(last_o));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Request side: reset, directed table, random phases, back-pressure, then drain.
  initial begin : stimulus
    request_t directed_rows [$];
    int       phase_idle [4];
    int       phase_stall [4];
    int       ph;
    int       n;
    phase_idle  = '{0, 62, 0, 21};
    phase_stall = '{0, 0, 62, 21};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, extremes of time, equal deadlines and an ignored action.
    directed_rows.push_back(req_row(stq_pkg::ACT_UPDATE, 8'h00, T_MAX, '0));
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_UNSCHEDULE, 8'h55, T_MAX, T_MAX),
                                        stq_pkg::KIND_NOT_FOUND, 8'h55, '0));
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_SCHEDULE, 8'h00, '0, T_MAX),
                                        stq_pkg::KIND_EARLY, 8'h00, '0));
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_SCHEDULE, 8'hFF, T_MAX, '0),
                                        stq_pkg::KIND_EARLY, 8'hFF, '0));
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_UPDATE, 8'hFF, T_MAX, '0),
                                        stq_pkg::KIND_FIRED, 8'h00, '0));
    directed_rows.push_back(req_row(stq_pkg::ACT_SCHEDULE, 8'h20, 48'd100, '0));
    directed_rows.push_back(req_row(stq_pkg::ACT_SCHEDULE, 8'h10, 48'd100, '0));
    directed_rows.push_back(req_row(stq_pkg::ACT_NONE, 8'hFF, T_MAX, T_MAX));
    directed_rows.push_back(req_row(stq_pkg::ACT_UPDATE, 8'h00, '0, 48'd99));
    // Fill the queue with shared ids, then hit the full and duplicate cases.
    for (n = 0; n < FILL_ITEMS; n++) begin
      directed_rows.push_back(req_row(stq_pkg::ACT_SCHEDULE, IW'(n % 5 + 1),
                                      FW'($urandom_range(200)), rand_time()));
    end
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_SCHEDULE, 8'hAB, rand_time(),
                                                rand_time()),
                                        stq_pkg::KIND_FULL, 8'hAB, '0));
    directed_rows.push_back(with_result(req_row(stq_pkg::ACT_UNSCHEDULE, 8'h03, rand_time(),
                                                rand_time()),
                                        stq_pkg::KIND_REMOVED, 8'h03, '0));
    directed_rows.push_back(req_row(stq_pkg::ACT_UPDATE, 8'h00, '0, T_MAX));
    foreach (directed_rows[r]) send_request(directed_rows[r]);

    // Random traffic under each idling mix.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      time_base      = rand_time();
      for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request(45));
    end

    // Back-pressure: the result side holds off while requests keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (n = 0; n < PRESSURE_ITEMS; n++) send_request(random_request(70));

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
